### src/aip_pkg.sv
// Shared types, character codes and helpers for the ASCII integer parser.
// No dependencies; the step logic, the top level and the bench import this package.
`timescale 1ns / 1ps

package aip_pkg;

   // Saturation point of the consumed-character count
   localparam int COUNT_MAX   = 255;
   localparam int COUNT_LIMIT = (COUNT_MAX < 255) ? COUNT_MAX : 255;

   // Parse phases
   localparam logic [1:0] PHASE_IDLE   = 2'd0;
   localparam logic [1:0] PHASE_ZERO   = 2'd1;
   localparam logic [1:0] PHASE_DIGITS = 2'd2;

   // Result width codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_DIGITS = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   // Character codes
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;

   // One accepted request beat
   typedef struct packed {
      logic [7:0] char_code;
      logic       start_req;
      logic [1:0] width_code;
      logic       hex_mode;
      logic       negate;
   } aip_req_type;

   // One result beat
   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  status;
      logic [7:0]  consumed;
   } aip_rsp_type;

   // Parser state carried from one character to the next
   typedef struct packed {
      logic [63:0] accumulator;
      logic [1:0]  phase;
      logic        effective_hex;
      logic [1:0]  latched_width;
      logic        latched_negate;
      logic        digit_seen;
      logic        overflowed;
      logic [7:0]  char_count;
   } aip_state_type;

   function automatic logic [63:0] width_mask(input logic [1:0] code);
      logic [63:0] mask;
      case (code)
         WIDTH_8:  mask = 64'h0000_0000_0000_00FF;
         WIDTH_16: mask = 64'h0000_0000_0000_FFFF;
         WIDTH_32: mask = 64'h0000_0000_FFFF_FFFF;
         default:  mask = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return mask;
   endfunction

endpackage

### src/aip_channels.sv
// Valid/ready channel interfaces for the parser's request and result beats.
// Depends on nothing; widths follow the field definitions of the block.
`timescale 1ns / 1ps

interface aip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       start_req;
   logic [1:0] width_code;
   logic       hex_mode;
   logic       negate;

   modport source (output valid, output char_code, output start_req,
                   output width_code, output hex_mode, output negate,
                   input ready);
   modport sink (input valid, input char_code, input start_req,
                 input width_code, input hex_mode, input negate,
                 output ready);
endinterface

interface aip_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [1:0]  status;
   logic [7:0]  consumed;

   modport source (output valid, output value, output status, output consumed,
                   input ready);
   modport sink (input valid, input value, input status, input consumed,
                 output ready);
endinterface

### src/aip_step.sv
// Next-state and result logic for one character of the ASCII integer parser.
// Purely combinational; uses types and helpers from aip_pkg.
`timescale 1ns / 1ps

module aip_step
   import aip_pkg::*;
#(
   parameter int COUNT_MAX = aip_pkg::COUNT_MAX
)
(
   input  aip_state_type state_cur,
   input  aip_req_type   req_cur,
   output aip_state_type state_nxt,
   output logic          rsp_hit,
   output aip_rsp_type   rsp_data
);

   // Consumed count never goes past what eight bits can hold
   localparam int COUNT_SAT = (COUNT_MAX < 255) ? COUNT_MAX : 255;

   aip_state_type pre;
   logic          do_digit;
   logic          is_digit;
   logic [3:0]    digit;
   logic [63:0]   mask;
   logic [68:0]   scaled;
   logic [68:0]   sum;
   logic [63:0]   neg_acc;

   // Apply start / prefix handling, decide whether the char goes to the digit step
   always_comb begin
      pre      = state_cur;
      do_digit = 1'b0;
      if (req_cur.start_req) begin
         pre.latched_width  = req_cur.width_code;
         pre.effective_hex  = req_cur.hex_mode;
         pre.latched_negate = req_cur.negate;
         pre.accumulator    = '0;
         pre.digit_seen     = 1'b0;
         pre.overflowed     = 1'b0;
         pre.char_count     = '0;
         if (!req_cur.hex_mode && req_cur.char_code == CHAR_0) begin
            pre.phase = PHASE_ZERO;
         end else begin
            pre.phase = PHASE_DIGITS;
            do_digit  = 1'b1;
         end
      end else begin
         case (state_cur.phase)
            PHASE_ZERO: begin
               pre.phase = PHASE_DIGITS;
               if (req_cur.char_code == CHAR_LOW_X) begin
                  pre.effective_hex = 1'b1;
                  pre.char_count    = 8'd2;
               end else begin
                  // the pending zero was a decimal digit
                  pre.effective_hex = 1'b0;
                  pre.digit_seen    = 1'b1;
                  pre.accumulator   = '0;
                  pre.char_count    = 8'd1;
                  do_digit          = 1'b1;
               end
            end
            PHASE_DIGITS: do_digit = 1'b1;
            default:      do_digit = 1'b0;
         endcase
      end
   end

   // Decode the character as a digit of the current base
   always_comb begin
      is_digit = 1'b1;
      digit    = '0;
      if (req_cur.char_code inside {[CHAR_0:CHAR_9]}) begin
         digit = 4'(req_cur.char_code - CHAR_0);
      end else if (pre.effective_hex && (req_cur.char_code inside {[CHAR_LOW_A:CHAR_LOW_F]})) begin
         digit = 4'(req_cur.char_code - CHAR_LOW_A + 8'd10);
      end else if (pre.effective_hex && (req_cur.char_code inside {[CHAR_UP_A:CHAR_UP_F]})) begin
         digit = 4'(req_cur.char_code - CHAR_UP_A + 8'd10);
      end else begin
         is_digit = 1'b0;
      end
   end

   // Shift-add multiply by the base and add the digit; exact, so no wrap
   assign mask    = width_mask(pre.latched_width);
   assign scaled  = pre.effective_hex ? {1'b0, pre.accumulator, 4'b0000}
                                      : ({2'b00, pre.accumulator, 3'b000}
                                         + {4'b0000, pre.accumulator, 1'b0});
   assign sum     = scaled + {65'd0, digit};
   assign neg_acc = 64'd0 - pre.accumulator;

   // Advance the digit run or close the number
   always_comb begin
      state_nxt = pre;
      rsp_hit   = 1'b0;
      rsp_data  = '0;
      rsp_data.consumed = pre.char_count;
      if (pre.overflowed) begin
         rsp_data.status = STATUS_OVERFLOW;
      end else if (!pre.digit_seen) begin
         rsp_data.status = STATUS_NO_DIGITS;
      end else begin
         rsp_data.status = STATUS_OK;
         rsp_data.value  = (pre.latched_negate ? neg_acc : pre.accumulator) & mask;
      end
      if (do_digit) begin
         if (!is_digit) begin
            rsp_hit         = 1'b1;
            state_nxt.phase = PHASE_IDLE;
         end else begin
            if (pre.char_count < 8'(COUNT_SAT)) begin
               state_nxt.char_count = pre.char_count + 8'd1;
            end
            state_nxt.digit_seen = 1'b1;
            if (!pre.overflowed) begin
               if (sum > {5'd0, mask}) begin
                  state_nxt.overflowed  = 1'b1;
                  state_nxt.accumulator = '0;
               end else begin
                  state_nxt.accumulator = sum[63:0];
               end
            end
         end
      end
   end

endmodule

### src/ascii_integer_parser.sv
// ASCII integer parser top level: input register, step logic, result register.
// Depends on aip_pkg, aip_channels (aip_req_if, aip_rsp_if) and aip_step.
//
//   channel   direction  beat contents
//   req_bus   in         char_code, start_req, width_code, hex_mode, negate
//   rsp_bus   out        value, status, consumed (one beat per finished number)
//
// A character beat is held in the input register while the step logic works on it;
// once the result slot is free, its result is registered in the result register and
// can then be taken. A new character is taken every cycle while no result is stalled.
// Synchronous active-high reset returns the parser to idle with no open number.
// A stalled result holds the step stage; the input register then fills and
// req_bus.ready drops until the result is taken.
`timescale 1ns / 1ps

module ascii_integer_parser
   import aip_pkg::*;
#(
   parameter int COUNT_MAX = aip_pkg::COUNT_MAX
)
(
   input logic         clock,
   input logic         reset,
   aip_req_if.sink     req_bus,
   aip_rsp_if.source   rsp_bus
);

   logic          in_valid_ff, in_valid_in;
   aip_req_type   in_data_ff, in_data_in;
   aip_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   aip_rsp_type   rsp_data_ff, rsp_data_in;

   aip_state_type step_state;
   logic          step_hit;
   aip_rsp_type   step_rsp;
   logic          fire;
   logic          req_take;

   // Step stage runs when a beat is held and the result slot can take a beat
   assign fire     = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_bus.ready    = !in_valid_ff || fire;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.value    = rsp_data_ff.value;
   assign rsp_bus.status   = rsp_data_ff.status;
   assign rsp_bus.consumed = rsp_data_ff.consumed;

   aip_step #(
      .COUNT_MAX (COUNT_MAX)
   ) u_step (
      .state_cur (state_ff),
      .req_cur   (in_data_ff),
      .state_nxt (step_state),
      .rsp_hit   (step_hit),
      .rsp_data  (step_rsp)
   );

   // Capture request beats into the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in           = 1'b1;
         in_data_in.char_code  = req_bus.char_code;
         in_data_in.start_req  = req_bus.start_req;
         in_data_in.width_code = req_bus.width_code;
         in_data_in.hex_mode   = req_bus.hex_mode;
         in_data_in.negate     = req_bus.negate;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Advance parser state and load or drop the result beat
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         state_in     = step_state;
         rsp_valid_in = step_hit;
         if (step_hit) begin
            rsp_data_in = step_rsp;
         end
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{accumulator: '0, phase: PHASE_IDLE, effective_hex: 1'b0,
                           latched_width: WIDTH_8, latched_negate: 1'b0,
                           digit_seen: 1'b0, overflowed: 1'b0, char_count: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### tb/tb.sv
// Self-checking bench for ascii_integer_parser: character beats in, parsed numbers out.
// Depends on aip_pkg and the aip_req_if / aip_rsp_if interfaces of the block.
`timescale 1ns / 1ps

module tb;
   import aip_pkg::*;

   // Tracks the open number and queues the result each terminated number must give
   class parse_scoreboard;
      logic [63:0] acc;
      logic [1:0]  stage;
      logic        hex_base;
      logic [1:0]  width_sel;
      logic        neg_sel;
      logic        seen_digit;
      logic        ovf;
      logic [7:0]  count;
      aip_rsp_type number_q[$];
      int          errors;
      int          reported;

      function new();
         acc        = '0;
         stage      = PHASE_IDLE;
         hex_base   = 1'b0;
         width_sel  = WIDTH_8;
         neg_sel    = 1'b0;
         seen_digit = 1'b0;
         ovf        = 1'b0;
         count      = '0;
         errors     = 0;
         reported   = 0;
      endfunction

      function logic [63:0] value_mask(input logic [1:0] code);
         if (code == WIDTH_64) begin
            return '1;
         end
         return (64'd1 << (8 << code)) - 64'd1;
      endfunction

      // Value of c as a digit of the base, -1 when it is not one
      function int digit_value(input logic [7:0] c, input bit hexbase);
         if (c >= CHAR_0 && c <= CHAR_9) begin
            return int'(c) - int'(CHAR_0);
         end
         if (hexbase && c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
            return int'(c) - int'(CHAR_LOW_A) + 10;
         end
         if (hexbase && c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            return int'(c) - int'(CHAR_UP_A) + 10;
         end
         return -1;
      endfunction

      // Close the open number and queue its result
      function void close_number();
         aip_rsp_type r;
         logic [63:0] mask;
         mask    = value_mask(width_sel);
         r.value = '0;
         if (ovf) begin
            r.status = STATUS_OVERFLOW;
         end else if (!seen_digit) begin
            r.status = STATUS_NO_DIGITS;
         end else begin
            r.status = STATUS_OK;
            r.value  = neg_sel ? ((64'd0 - acc) & mask) : (acc & mask);
         end
         r.consumed = count;
         stage = PHASE_IDLE;
         number_q.push_back(r);
      endfunction

      // Fold one character into the running value, or end the number on a non-digit
      function void take_char(input logic [7:0] c);
         int          d;
         logic [63:0] base;
         logic [63:0] mask;
         d = digit_value(c, hex_base);
         if (d < 0) begin
            close_number();
            return;
         end
         if (count < COUNT_LIMIT) begin
            count = count + 8'd1;
         end
         seen_digit = 1'b1;
         if (!ovf) begin
            base = hex_base ? 64'd16 : 64'd10;
            mask = value_mask(width_sel);
            if (acc > (mask - 64'(d)) / base) begin
               ovf = 1'b1;
               acc = '0;
            end else begin
               acc = acc * base + 64'(d);
            end
         end
      endfunction

      function void note_char(input aip_req_type beat);
         if (beat.start_req) begin
            width_sel  = beat.width_code;
            hex_base   = beat.hex_mode;
            neg_sel    = beat.negate;
            acc        = '0;
            seen_digit = 1'b0;
            ovf        = 1'b0;
            count      = '0;
            // hold a leading zero until we know whether a prefix follows
            if (!hex_base && beat.char_code == CHAR_0) begin
               stage = PHASE_ZERO;
               return;
            end
            stage = PHASE_DIGITS;
            take_char(beat.char_code);
            return;
         end
         if (stage == PHASE_ZERO) begin
            if (beat.char_code == CHAR_LOW_X) begin
               hex_base = 1'b1;
               count    = 8'd2;
               stage    = PHASE_DIGITS;
               return;
            end
            // the held zero was a decimal digit after all
            hex_base   = 1'b0;
            seen_digit = 1'b1;
            acc        = '0;
            count      = 8'd1;
            stage      = PHASE_DIGITS;
            take_char(beat.char_code);
            return;
         end
         if (stage == PHASE_DIGITS) begin
            take_char(beat.char_code);
         end
      endfunction

      function void check_result(input aip_rsp_type got);
         aip_rsp_type want;
         if (number_q.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("%0t: unexpected result value=%h status=%0d consumed=%0d",
                        $realtime, got.value, got.status, got.consumed);
            end
            return;
         end
         want = number_q.pop_front();
         if (got.value !== want.value || got.status !== want.status ||
             got.consumed !== want.consumed) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("%0t: result mismatch: expected value=%h status=%0d consumed=%0d",
                        $realtime, want.value, want.status, want.consumed);
               $display("%0t:                   actual value=%h status=%0d consumed=%0d",
                        $realtime, got.value, got.status, got.consumed);
            end
         end
      endfunction

      function int pending();
         return number_q.size();
      endfunction

      function void close_out();
         if (number_q.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $realtime, number_q.size());
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   aip_req_if req_bus ();
   aip_rsp_if rsp_bus ();

   ascii_integer_parser u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   parse_scoreboard sb;
   int              idle_pct = 0;
   int              stall_pct = 0;
   int              beats_sent = 0;
   int              numbers_built = 0;
   logic [7:0]      text_buf[$];

   always #5 clock = ~clock;

   // Drive result backpressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watch both channels and score every beat
   always @(posedge clock) begin
      aip_req_type req_beat;
      aip_rsp_type rsp_beat;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_beat.value    = rsp_bus.value;
            rsp_beat.status   = rsp_bus.status;
            rsp_beat.consumed = rsp_bus.consumed;
            sb.check_result(rsp_beat);
         end
         if (req_bus.valid && req_bus.ready) begin
            req_beat.char_code  = req_bus.char_code;
            req_beat.start_req  = req_bus.start_req;
            req_beat.width_code = req_bus.width_code;
            req_beat.hex_mode   = req_bus.hex_mode;
            req_beat.negate     = req_bus.negate;
            sb.note_char(req_beat);
         end
      end
   end

   // Offer one beat after a random gap and hold it until taken
   task automatic send_beat(input aip_req_type beat);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.char_code  <= beat.char_code;
      req_bus.start_req  <= beat.start_req;
      req_bus.width_code <= beat.width_code;
      req_bus.hex_mode   <= beat.hex_mode;
      req_bus.negate     <= beat.negate;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   // Send the buffered text; the first beat opens a number when asked
   task automatic send_text(input logic [1:0] w, input bit hx, input bit ng, input bit opens);
      aip_req_type beat;
      for (int i = 0; i < text_buf.size(); i++) begin
         beat.char_code = text_buf[i];
         beat.start_req = (i == 0) && opens;
         if (i == 0) begin
            beat.width_code = w;
            beat.hex_mode   = hx;
            beat.negate     = ng;
         end else begin
            beat.width_code = 2'($urandom);
            beat.hex_mode   = 1'($urandom);
            beat.negate     = 1'($urandom);
         end
         send_beat(beat);
      end
      text_buf.delete();
   endtask

   // Stop sending until every pending number has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text_buf.push_back(s[i]);
      end
   endtask

   // Append a character; a lower-case hex letter gets a random case
   task automatic add_letter(input logic [7:0] c);
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_F && $urandom_range(0, 1)) begin
         text_buf.push_back(c - CHAR_LOW_A + CHAR_UP_A);
      end else begin
         text_buf.push_back(c);
      end
   endtask

   task automatic add_digit(input bit hexbase);
      int d;
      d = hexbase ? $urandom_range(0, 15) : $urandom_range(0, 9);
      if (d < 10) begin
         text_buf.push_back(CHAR_0 + 8'(d));
      end else begin
         add_letter(CHAR_LOW_A + 8'(d - 10));
      end
   endtask

   function automatic logic [7:0] pick_stop(input bit hexbase);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (sb.digit_value(c, hexbase) >= 0);
      return c;
   endfunction

   // Build the text of one number: optional prefix, then a digit run
   task automatic build_number(input logic [1:0] w, input bit hx, output bit hexbase);
      int          kind;
      int          n;
      logic [63:0] v;
      string       s;
      bit          prefix;
      numbers_built++;
      prefix  = !hx && ($urandom_range(0, 99) < 30);
      hexbase = hx || prefix;
      if (prefix) begin
         text_buf.push_back(CHAR_0);
         text_buf.push_back(CHAR_LOW_X);
      end
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
         // land on, just below or just past the width maximum
         v = sb.value_mask(w) - 64'($urandom_range(0, 2));
         s = hexbase ? $sformatf("%0h", v) : $sformatf("%0d", v);
         if (kind < 10 && !hexbase) begin
            s.putc(s.len() - 1, s[s.len() - 1] + 8'd1);
         end
         for (int i = 0; i < s.len(); i++) begin
            add_letter(s[i]);
         end
         if (kind < 10 && hexbase) begin
            add_digit(hexbase);
         end
      end else begin
         if (numbers_built % 97 == 40) begin
            n = $urandom_range(250, 300);
         end else if (kind < 30) begin
            n = 0;
         end else if (kind < 75) begin
            n = $urandom_range(1, 4);
         end else begin
            n = $urandom_range(5, 20);
         end
         repeat (n) add_digit(hexbase);
      end
   endtask

   // Reset, directed text, then random text through phases of idle gaps and result stalls
   initial begin
      logic [1:0] w;
      bit         hx;
      bit         ng;
      bit         hexbase;
      int         target;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.char_code  = '0;
      req_bus.start_req  = 1'b0;
      req_bus.width_code = WIDTH_8;
      req_bus.hex_mode   = 1'b0;
      req_bus.negate     = 1'b0;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // digit while idle: dropped
      add_str("5");
      send_text(WIDTH_8, 1'b0, 1'b0, 1'b0);
      // byte maximum, then one past it
      add_str("255 ");
      send_text(WIDTH_8, 1'b0, 1'b0, 1'b1);
      add_str("256;");
      send_text(WIDTH_8, 1'b0, 1'b1, 1'b1);
      // prefix with mixed-case hex, negated
      add_str("0xfFg");
      send_text(WIDTH_16, 1'b0, 1'b1, 1'b1);
      // prefix with no hex digits, stopped by the top character code
      add_str("0x");
      text_buf.push_back(8'hFF);
      send_text(WIDTH_32, 1'b0, 1'b0, 1'b1);
      // forced hex, no digit at all
      add_str("/");
      send_text(WIDTH_64, 1'b1, 1'b0, 1'b1);
      // upper-case X is no prefix: lone zero
      add_str("0X");
      send_text(WIDTH_8, 1'b0, 1'b0, 1'b1);
      // open number dropped by a new start
      add_str("07");
      send_text(WIDTH_16, 1'b0, 1'b0, 1'b1);
      add_str("A@");
      send_text(WIDTH_32, 1'b1, 1'b1, 1'b1);
      drain();

      target = beats_sent;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         target += 350;
         while (beats_sent < target) begin
            // mix in stray beats now and then
            if ($urandom_range(0, 99) < 10) begin
               repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom));
               send_text(2'($urandom), 1'($urandom), 1'($urandom),
                         $urandom_range(0, 99) < 30);
            end
            w  = 2'($urandom);
            hx = $urandom_range(0, 99) < 35;
            ng = 1'($urandom);
            build_number(w, hx, hexbase);
            if (text_buf.size() == 0 || $urandom_range(0, 99) < 85) begin
               text_buf.push_back(pick_stop(hexbase));
            end
            send_text(w, hx, ng, 1'b1);
         end
         drain();
      end

      repeat (8) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### sim.f
src/aip_pkg.sv
src/aip_channels.sv
src/aip_step.sv
src/ascii_integer_parser.sv
tb/tb.sv
